[rtl/ssfi_pkg.sv]
// shared constants, payload types and cell control for the sorted set block
package ssfi_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;

	typedef struct packed {
		logic                       command;
		logic signed [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             inserted;
		logic             full_error;
	} rsp_t;

	typedef struct packed {
		logic cmp;
		logic wr;
	} cell_ctrl_t;

endpackage

[rtl/ssfi_cell.sv]
// one slot of the sorted list: holds a key, compares it, shifts in from its lower neighbor
module ssfi_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssfi_pkg::cell_ctrl_t                ctrl,
	input  logic signed [ssfi_pkg::KEY_BITS-1:0] cmp_key,
	input  logic signed [ssfi_pkg::KEY_BITS-1:0] new_key,
	input  logic                                occupied,
	input  logic signed [ssfi_pkg::KEY_BITS-1:0] left_key,
	input  logic                                left_lt,
	output logic signed [ssfi_pkg::KEY_BITS-1:0] entry_q,
	output logic                                lt_s1,
	output logic                                eq_s1
);
	import ssfi_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else if (ctrl.cmp) begin
			lt_s1 <= occupied && (entry_q < cmp_key);
			eq_s1 <= occupied && (entry_q == cmp_key);
		end
	end

	// the insert slot takes the new key, every slot above it takes its neighbor
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			if (!left_lt) begin
				entry_q <= left_key;
			end else if (!lt_s1) begin
				entry_q <= new_key;
			end
		end
	end

endmodule

[rtl/ssfi_resolve.sv]
// turns the per-slot compare flags into found and insert position
module ssfi_resolve (
	input  logic [ssfi_pkg::CAPACITY-1:0] lt,
	input  logic [ssfi_pkg::CAPACITY-1:0] eq,
	output logic                          found,
	output logic [ssfi_pkg::CNT_W-1:0]    pos
);
	import ssfi_pkg::*;

	logic lo_side;
	logic hi_side;

	assign found = |eq;

	// lt is a thermometer code, so exactly one boundary exists
	always_comb begin
		pos = '0;
		for (int i = 0; i <= CAPACITY; i++) begin
			lo_side = (i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1];
			hi_side = (i == CAPACITY) ? 1'b1 : !lt[(i == CAPACITY) ? 0 : i];
			if (lo_side && hi_side) begin
				pos = pos | CNT_W'(i);
			end
		end
	end

endmodule

[rtl/sorted_set_find_insert.sv]
// top level: sorted set of signed keys with find and ordered insert
// For each command, on the input transfer every slot of a row of CAPACITY
// cells compares its key with the incoming one in parallel. Once the result
// register is free, the boundary of the flags gives found and the position;
// a new key with room shifts cells above up by one and fills the insert slot.
// The input stalls only while a command is in flight; a command stays in flight
// while the result register still holds an earlier result that is stalled, and a
// result waiting on the output does not block the next input transfer.
module sorted_set_find_insert (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ssfi_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ssfi_pkg::rsp_t rsp
);
	import ssfi_pkg::*;

	logic                       busy_q;
	logic                       cmd_s1;
	logic signed [KEY_BITS-1:0] key_s1;
	logic [CNT_W-1:0]           count_q;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;

	logic                       accept;
	logic                       resolve;
	logic                       found;
	logic [CNT_W-1:0]           pos;
	logic                       full;
	logic                       do_insert;
	cell_ctrl_t                 ctrl;

	logic signed [KEY_BITS-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]        lt;
	logic [CAPACITY-1:0]        eq;

	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign resolve   = busy_q && (!rsp_valid_q || !rsp_stall);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign do_insert = resolve && cmd_s1 && !found && !full;
	assign ctrl.cmp  = accept;
	assign ctrl.wr   = do_insert;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssfi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.cmp_key  (req.key),
			.new_key  (key_s1),
			.occupied (count_q > CNT_W'(i)),
			.left_key ((i == 0) ? key_s1 : entry[(i == 0) ? 0 : i - 1]),
			.left_lt  ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
			.entry_q  (entry[i]),
			.lt_s1    (lt[i]),
			.eq_s1    (eq[i])
		);
	end

	ssfi_resolve u_resolve (
		.lt    (lt),
		.eq    (eq),
		.found (found),
		.pos   (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (resolve) begin
				busy_q <= 1'b0;
			end
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (resolve) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.command;
			key_s1 <= req.key;
		end
		if (resolve) begin
			rsp_q.found      <= found;
			rsp_q.position   <= POS_W'(pos);
			rsp_q.inserted   <= cmd_s1 && !found && !full;
			rsp_q.full_error <= cmd_s1 && !found && full;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
